/* hdl/text_terminal_escape_engine_macros.svh */
// Assertion macros shared by the terminal engine RTL.
`ifndef TEXT_TERMINAL_ESCAPE_ENGINE_MACROS_SVH
`define TEXT_TERMINAL_ESCAPE_ENGINE_MACROS_SVH

// Implication checked outside of reset.
`define TTEE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked at every edge, reset included.
`define TTEE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/ttee_pkg.sv */
// ----------------------------------------------------------------------------
// Terminal escape engine package
// Shared types, screen geometry and character codes.
// ----------------------------------------------------------------------------
package ttee_pkg;

   localparam int ROWS  = 24;
   localparam int COLS  = 80;
   localparam int CELLS = ROWS * COLS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);

   localparam logic [4:0] ROW_NUM  = 5'(ROWS);
   localparam logic [4:0] ROW_LAST = 5'(ROWS - 1);
   localparam logic [6:0] COL_NUM  = 7'(COLS);
   localparam logic [6:0] COL_LAST = 7'(COLS - 1);
   localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] LAST_ROW_BASE = ADDR_W'((ROWS - 1) * COLS);

   localparam logic [7:0] CH_BEL   = 8'd7;
   localparam logic [7:0] CH_BS    = 8'd8;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_LF    = 8'd10;
   localparam logic [7:0] CH_FF    = 8'd12;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_ESC   = 8'd27;
   localparam logic [7:0] CH_GS    = 8'd29;
   localparam logic [7:0] CH_US    = 8'd31;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_DEL_LIMIT = 8'd128;

   localparam logic [7:0] ESC_UP    = 8'h41;
   localparam logic [7:0] ESC_DOWN  = 8'h42;
   localparam logic [7:0] ESC_RIGHT = 8'h43;
   localparam logic [7:0] ESC_LEFT  = 8'h44;
   localparam logic [7:0] ESC_CLEAR = 8'h45;
   localparam logic [7:0] ESC_HOME  = 8'h48;
   localparam logic [7:0] ESC_EOP   = 8'h4A;
   localparam logic [7:0] ESC_EOL   = 8'h4B;
   localparam logic [7:0] ESC_INSL  = 8'h4C;
   localparam logic [7:0] ESC_DELL  = 8'h4D;
   localparam logic [7:0] ESC_STON  = 8'h4E;
   localparam logic [7:0] ESC_STOFF = 8'h4F;
   localparam logic [7:0] ESC_ADDR  = 8'h59;
   localparam logic [7:0] ESC_INSC  = 8'h6C;
   localparam logic [7:0] ESC_DELC  = 8'h6D;
   localparam logic [7:0] ESC_HLON  = 8'h70;
   localparam logic [7:0] ESC_HLOFF = 8'h71;

   typedef struct packed {
      logic       command;
      logic [7:0] char_in;
      logic [4:0] read_row;
      logic [6:0] read_col;
   } ttee_req_type;

   typedef struct packed {
      logic [7:0] cell_char;
      logic [4:0] cursor_row;
      logic [6:0] cursor_col;
      logic [7:0] echo_char;
      logic       echo_valid;
      logic       graphics_valid;
      logic       bell;
      logic       graphics_mode;
      logic       status_line_on;
      logic       highlight;
   } ttee_rsp_type;

   typedef struct packed {
      ttee_rsp_type      rsp;
      logic              do_copy;
      logic              copy_desc;
      logic              copy_row;
      logic [ADDR_W-1:0] copy_start;
      logic [ADDR_W-1:0] copy_stop;
      logic              do_fill;
      logic [ADDR_W-1:0] fill_start;
      logic [ADDR_W-1:0] fill_stop;
      logic              do_write;
      logic [ADDR_W-1:0] write_addr;
      logic [7:0]        write_char;
      logic              do_read;
      logic [ADDR_W-1:0] read_addr;
   } ttee_job_type;

   function automatic logic [ADDR_W-1:0] row_base(input logic [4:0] r);
      return ADDR_W'(r) * ADDR_W'(COLS);
   endfunction

   function automatic logic [6:0] addr_value(input logic [7:0] b, input logic [6:0] limit);
      logic [7:0] d;
      d = b - CH_SPACE;
      if (b < CH_SPACE) return 7'd0;
      if (d >= {1'b0, limit}) return limit - 7'd1;
      return d[6:0];
   endfunction

endpackage

/* hdl/text_terminal_escape_engine.sv */
// ----------------------------------------------------------------------------
// Text terminal escape engine
// Character screen, cursor and escape decoding for a VT52-style terminal.
// ----------------------------------------------------------------------------
// Usage: items enter as req_data beats when push is high and full is low. A
// command of 0 feeds one terminal byte, a command of 1 reads one screen cell.
// Every item gives exactly one rsp_data beat, presented while empty is low
// and taken when pop is high. While full is low the decoder takes a byte each
// cycle into a four-entry job queue; the screen unit then runs each job on a
// character store with one write and one read port at one cell per cycle.
// A printable byte or a read also passes a store write or read before its beat;
// an end-of-line clear, scroll, line insert, line delete or full clear run over
// each cell they touch through the store's one write port. After reset the store
// is swept to spaces with full held high. When the receiver stalls, the result
// register holds its beat, the job queue fills and full rises until pop is seen
// again.
// ----------------------------------------------------------------------------
`include "text_terminal_escape_engine_macros.svh"

module text_terminal_escape_engine import ttee_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  ttee_req_type req_data,
   output logic         empty,
   input  logic         pop,
   output ttee_rsp_type rsp_data
);

   logic         accept, q_full, q_empty, q_pop, clearing;
   ttee_job_type front_job, head_job;

   assign full = q_full || clearing;
   assign accept = push && !full;

   ttee_front u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .req    (req_data),
      .job    (front_job)
   );

   ttee_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (accept),
      .push_job (front_job),
      .full     (q_full),
      .pop      (q_pop),
      .empty    (q_empty),
      .head_job (head_job)
   );

   ttee_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_ready (!q_empty),
      .job       (head_job),
      .job_pop   (q_pop),
      .clearing  (clearing),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_data  (rsp_data)
   );

   `TTEE_ASSERT_NXT(a_reset_blocks, reset, full, "input open during clearing sweep")
   `TTEE_ASSERT_IMP(a_row_range, !empty, rsp_data.cursor_row <= ROW_NUM, "cursor row out of range")
   `TTEE_ASSERT_IMP(a_col_range, !empty, rsp_data.cursor_col < COL_NUM, "cursor col out of range")
   `TTEE_ASSERT_IMP(a_echo_kind, !empty, !(rsp_data.echo_valid && rsp_data.graphics_valid),
      "text and graphics echo together")

endmodule

/* hdl/ttee_front.sv */
// ----------------------------------------------------------------------------
// Terminal escape engine front end
// Decodes each byte, keeps cursor and mode state and issues screen jobs.
// ----------------------------------------------------------------------------
module ttee_front import ttee_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         accept,
   input  ttee_req_type req,
   output ttee_job_type job
);

   logic [4:0] row_ff, row_in, saved_row_ff, saved_row_in;
   logic [6:0] col_ff, col_in, saved_col_ff, saved_col_in;
   logic       esc_ff, esc_in, graph_ff, graph_in, status_ff, status_in, light_ff, light_in;
   logic [1:0] left_ff, left_in;

   always_comb begin
      logic              nl, ev, gv, bel, row_ok;
      logic [7:0]        b, echo, tab;
      logic [ADDR_W-1:0] base, pos;
      row_in = row_ff;
      col_in = col_ff;
      saved_row_in = saved_row_ff;
      saved_col_in = saved_col_ff;
      esc_in = esc_ff;
      graph_in = graph_ff;
      status_in = status_ff;
      light_in = light_ff;
      left_in = left_ff;
      job = '0;
      nl = 1'b0;
      ev = 1'b0;
      gv = 1'b0;
      bel = 1'b0;
      echo = 8'd0;
      b = req.char_in;
      tab = {col_ff[6:3] + 5'd1, 3'b000};
      base = row_base(row_ff);
      pos = base + ADDR_W'(col_ff);
      row_ok = row_ff < ROW_NUM;
      if (req.command) begin
         job.do_read = (req.read_row < ROW_NUM) && (req.read_col < COL_NUM);
         job.read_addr = row_base(req.read_row) + ADDR_W'(req.read_col);
      end else if (esc_ff) begin
         esc_in = 1'b0;
         case (b)
            ESC_UP: begin
               if (row_ff != 5'd0) row_in = (row_ff > ROW_NUM) ? ROW_LAST : row_ff - 5'd1;
            end
            ESC_DOWN: row_in = (row_ff < ROW_LAST) ? row_ff + 5'd1 : ROW_LAST;
            ESC_RIGHT: begin
               if (col_ff < COL_LAST) col_in = col_ff + 7'd1;
               else begin
                  col_in = 7'd0;
                  nl = 1'b1;
               end
            end
            ESC_LEFT: if (col_ff != 7'd0) col_in = col_ff - 7'd1;
            CH_FF, ESC_CLEAR: begin
               job.do_fill = 1'b1;
               job.fill_start = '0;
               job.fill_stop = CELL_LAST;
               row_in = 5'd0;
               col_in = 7'd0;
            end
            ESC_HOME: begin
               row_in = 5'd0;
               col_in = 7'd0;
            end
            ESC_EOP: begin
               job.do_fill = row_ok;
               job.fill_start = pos;
               job.fill_stop = CELL_LAST;
            end
            ESC_EOL: begin
               job.do_fill = row_ok;
               job.fill_start = pos;
               job.fill_stop = base + ADDR_W'(COLS - 1);
            end
            ESC_INSL: begin
               job.do_copy = row_ok && (row_ff != ROW_LAST);
               job.copy_desc = 1'b1;
               job.copy_row = 1'b1;
               job.copy_start = CELL_LAST;
               job.copy_stop = base + ADDR_W'(COLS);
               job.do_fill = row_ok;
               job.fill_start = base;
               job.fill_stop = base + ADDR_W'(COLS - 1);
               col_in = 7'd0;
            end
            ESC_DELL: begin
               job.do_copy = row_ok && (row_ff != ROW_LAST);
               job.copy_row = 1'b1;
               job.copy_start = base;
               job.copy_stop = LAST_ROW_BASE - ADDR_W'(1);
               job.do_fill = 1'b1;
               job.fill_start = LAST_ROW_BASE;
               job.fill_stop = CELL_LAST;
               col_in = 7'd0;
            end
            ESC_STON: begin
               if (!status_ff) begin
                  saved_row_in = row_ff;
                  saved_col_in = col_ff;
               end
               status_in = 1'b1;
               row_in = ROW_NUM;
               col_in = 7'd0;
               light_in = 1'b1;
            end
            ESC_STOFF: begin
               light_in = 1'b0;
               row_in = saved_row_ff;
               col_in = saved_col_ff;
               status_in = 1'b0;
            end
            ESC_ADDR: left_in = 2'd2;
            ESC_INSC: begin
               job.do_copy = row_ok && (col_ff != COL_LAST);
               job.copy_desc = 1'b1;
               job.copy_start = base + ADDR_W'(COLS - 1);
               job.copy_stop = pos + ADDR_W'(1);
               job.do_write = row_ok;
               job.write_addr = pos;
               job.write_char = CH_SPACE;
            end
            ESC_DELC: begin
               job.do_copy = row_ok && (col_ff != COL_LAST);
               job.copy_start = pos;
               job.copy_stop = base + ADDR_W'(COLS - 2);
               job.do_write = row_ok;
               job.write_addr = base + ADDR_W'(COLS - 1);
               job.write_char = CH_SPACE;
            end
            ESC_HLON: light_in = 1'b1;
            ESC_HLOFF: light_in = 1'b0;
            default: ;
         endcase
      end else if (left_ff != 2'd0) begin
         if (left_ff == 2'd2) row_in = 5'(addr_value(b, 7'(ROWS)));
         else col_in = addr_value(b, COL_NUM);
         left_in = left_ff - 2'd1;
      end else if (status_ff && (b != CH_ESC)) begin
         echo = b;
         ev = 1'b1;
         col_in = (col_ff >= COL_LAST) ? COL_LAST : col_ff + 7'd1;
      end else if (graph_ff) begin
         if (b == CH_US) graph_in = 1'b0;
         else if (b == CH_ESC) esc_in = 1'b1;
         else begin
            echo = b;
            gv = 1'b1;
         end
      end else begin
         case (b)
            CH_CR: col_in = 7'd0;
            CH_LF: nl = 1'b1;
            CH_BEL: bel = 1'b1;
            CH_BS: if (col_ff != 7'd0) col_in = col_ff - 7'd1;
            CH_TAB: begin
               if (tab >= {1'b0, COL_NUM}) begin
                  col_in = 7'd0;
                  nl = 1'b1;
               end else col_in = tab[6:0];
            end
            CH_ESC: esc_in = 1'b1;
            CH_GS: graph_in = 1'b1;
            CH_US: graph_in = 1'b0;
            default: begin
               if ((b >= CH_SPACE) && (b < CH_DEL_LIMIT)) begin
                  job.do_write = row_ok;
                  job.write_addr = pos;
                  job.write_char = b;
                  echo = b;
                  ev = 1'b1;
                  if (col_ff >= COL_LAST) begin
                     col_in = 7'd0;
                     nl = 1'b1;
                  end else col_in = col_ff + 7'd1;
               end
            end
         endcase
      end
      if (nl) begin
         if (({1'b0, row_ff} + 6'd1) >= {1'b0, ROW_NUM}) begin
            job.do_copy = 1'b1;
            job.copy_desc = 1'b0;
            job.copy_row = 1'b1;
            job.copy_start = '0;
            job.copy_stop = LAST_ROW_BASE - ADDR_W'(1);
            job.do_fill = 1'b1;
            job.fill_start = LAST_ROW_BASE;
            job.fill_stop = CELL_LAST;
            if (job.do_write) job.write_addr = job.write_addr - ADDR_W'(COLS);
            row_in = ROW_LAST;
         end else row_in = row_ff + 5'd1;
      end
      job.rsp.cell_char = 8'd0;
      job.rsp.cursor_row = row_in;
      job.rsp.cursor_col = col_in;
      job.rsp.echo_char = echo;
      job.rsp.echo_valid = ev;
      job.rsp.graphics_valid = gv;
      job.rsp.bell = bel;
      job.rsp.graphics_mode = graph_in;
      job.rsp.status_line_on = status_in;
      job.rsp.highlight = light_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
         saved_row_ff <= '0;
         saved_col_ff <= '0;
         esc_ff <= 1'b0;
         left_ff <= '0;
         graph_ff <= 1'b0;
         status_ff <= 1'b0;
         light_ff <= 1'b0;
      end else if (accept) begin
         row_ff <= row_in;
         col_ff <= col_in;
         saved_row_ff <= saved_row_in;
         saved_col_ff <= saved_col_in;
         esc_ff <= esc_in;
         left_ff <= left_in;
         graph_ff <= graph_in;
         status_ff <= status_in;
         light_ff <= light_in;
      end
   end

endmodule

/* hdl/ttee_queue.sv */
// ----------------------------------------------------------------------------
// Terminal escape engine job queue
// Short first-in first-out store between the decoder and the screen unit.
// ----------------------------------------------------------------------------
module ttee_queue import ttee_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  ttee_job_type push_job,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output ttee_job_type head_job
);

   ttee_job_type      slot_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, rd_ff;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full = count_ff == (QPTR_W + 1)'(QDEPTH);
   assign empty = count_ff == '0;
   assign head_job = slot_ff[rd_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

/* hdl/ttee_back.sv */
// ----------------------------------------------------------------------------
// Terminal escape engine screen unit
// Owns the character store and runs copy, fill, write and read jobs.
// ----------------------------------------------------------------------------
module ttee_back import ttee_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         job_ready,
   input  ttee_job_type job,
   output logic         job_pop,
   output logic         clearing,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output ttee_rsp_type rsp_data
);

   localparam logic [3:0] B_CLEAR = 4'd0;
   localparam logic [3:0] B_IDLE  = 4'd1;
   localparam logic [3:0] B_RUN   = 4'd2;
   localparam logic [3:0] B_COPY  = 4'd3;
   localparam logic [3:0] B_DRAIN = 4'd4;
   localparam logic [3:0] B_FILL  = 4'd5;
   localparam logic [3:0] B_RWAIT = 4'd6;
   localparam logic [3:0] B_EMIT  = 4'd7;

   logic [7:0]        mem [CELLS];
   logic [7:0]        rdata_ff;
   logic [3:0]        state_ff, state_in;
   ttee_job_type      job_ff, job_in;
   logic [ADDR_W-1:0] addr_ff, addr_in, pend_ff, stride;
   logic              pend_v_ff;
   logic              we, re;
   logic [ADDR_W-1:0] waddr, raddr;
   logic [7:0]        wdata;
   logic              out_valid_ff, out_valid_in;
   ttee_rsp_type      out_ff;

   assign clearing = state_ff == B_CLEAR;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data = out_ff;
   assign stride = job_ff.copy_row ? ADDR_W'(COLS) : ADDR_W'(1);

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      addr_in = addr_ff;
      job_pop = 1'b0;
      we = pend_v_ff;
      waddr = pend_ff;
      wdata = rdata_ff;
      re = 1'b0;
      raddr = job_ff.copy_desc ? addr_ff - stride : addr_ff + stride;
      out_valid_in = out_valid_ff && !rsp_pop;
      case (state_ff)
         B_CLEAR: begin
            we = 1'b1;
            waddr = addr_ff;
            wdata = CH_SPACE;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == CELL_LAST) state_in = B_IDLE;
         end
         B_IDLE: begin
            if (job_ready) begin
               job_pop = 1'b1;
               job_in = job;
               state_in = B_RUN;
            end
         end
         B_RUN: begin
            if (job_ff.do_copy) begin
               addr_in = job_ff.copy_start;
               state_in = B_COPY;
            end else if (job_ff.do_fill) begin
               addr_in = job_ff.fill_start;
               state_in = B_FILL;
            end else if (job_ff.do_write) begin
               we = 1'b1;
               waddr = job_ff.write_addr;
               wdata = job_ff.write_char;
               job_in.do_write = 1'b0;
            end else if (job_ff.do_read) begin
               re = 1'b1;
               raddr = job_ff.read_addr;
               job_in.do_read = 1'b0;
               state_in = B_RWAIT;
            end else state_in = B_EMIT;
         end
         B_COPY: begin
            re = 1'b1;
            addr_in = job_ff.copy_desc ? addr_ff - 1'b1 : addr_ff + 1'b1;
            if (addr_ff == job_ff.copy_stop) state_in = B_DRAIN;
         end
         B_DRAIN: begin
            job_in.do_copy = 1'b0;
            state_in = B_RUN;
         end
         B_FILL: begin
            we = 1'b1;
            waddr = addr_ff;
            wdata = CH_SPACE;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == job_ff.fill_stop) begin
               job_in.do_fill = 1'b0;
               state_in = B_RUN;
            end
         end
         B_RWAIT: begin
            job_in.rsp.cell_char = rdata_ff;
            state_in = B_EMIT;
         end
         B_EMIT: begin
            if (!out_valid_ff || rsp_pop) begin
               out_valid_in = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      pend_ff <= addr_ff;
      if ((state_ff == B_EMIT) && (!out_valid_ff || rsp_pop)) out_ff <= job_ff.rsp;
      if (reset) begin
         state_ff <= B_CLEAR;
         addr_ff <= '0;
         pend_v_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff <= addr_in;
         pend_v_ff <= state_ff == B_COPY;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule
